/* src/mvng_pkg.sv */
// ----------------------------------------------------------------------------
// mvng_pkg
// Shared types and constants for the vertex normal generator.
// ----------------------------------------------------------------------------
package mvng_pkg;

    localparam int IDX_W   = 10;   // vertex index field
    localparam int POS_W   = 16;   // Q7.8 coordinate
    localparam int EDGE_W  = 17;   // difference of two coordinates
    localparam int CROSS_W = 36;   // cross product component, signed
    localparam int ACC_W   = 24;   // accumulator, signed
    localparam int NRM_W   = 16;   // Q1.14 normal component
    localparam int MAG_W   = 16;   // magnitude after common shift

    localparam logic signed [ACC_W-1:0] ACC_MAX = 24'sh7FFFFF;
    localparam logic signed [ACC_W-1:0] ACC_MIN = 24'sh800000;
    localparam logic [14:0]             UNIT_Q  = 15'd16384;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_TRI  = 2'd1,
        OP_READ = 2'd2
    } t_op;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_A,
        ST_RD_B,
        ST_RD_C,
        ST_EDGE,
        ST_CROSS,
        ST_CHECK,
        ST_TRI_NORM,
        ST_ACC_RD,
        ST_ACC_WR,
        ST_RD_ACC,
        ST_RD_CHK,
        ST_RD_NORM,
        ST_OUT
    } t_state;

    typedef enum logic [2:0] {
        NS_IDLE,
        NS_SHIFT,
        NS_SQ,
        NS_LEN,
        NS_SRCH,
        NS_DONE
    } t_nstate;

    typedef struct packed {
        logic                    done;
        logic signed [NRM_W-1:0] qx;
        logic signed [NRM_W-1:0] qy;
        logic signed [NRM_W-1:0] qz;
    } t_norm_res;

endpackage

/* src/mvng_if.sv */
// ----------------------------------------------------------------------------
// mvng_if
// Valid/ready channels for operation items and normal results.
// ----------------------------------------------------------------------------
interface mvng_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [1:0]                           operation;
    logic [mvng_pkg::IDX_W-1:0]           vertex_index;
    logic signed [mvng_pkg::POS_W-1:0]    pos_x;
    logic signed [mvng_pkg::POS_W-1:0]    pos_y;
    logic signed [mvng_pkg::POS_W-1:0]    pos_z;
    logic [mvng_pkg::IDX_W-1:0]           corner_a;
    logic [mvng_pkg::IDX_W-1:0]           corner_b;
    logic [mvng_pkg::IDX_W-1:0]           corner_c;

    modport source (output valid, operation, vertex_index, pos_x, pos_y, pos_z,
                    corner_a, corner_b, corner_c, input ready);
    modport sink   (input valid, operation, vertex_index, pos_x, pos_y, pos_z,
                    corner_a, corner_b, corner_c, output ready);
endinterface

interface mvng_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [mvng_pkg::NRM_W-1:0]    normal_x;
    logic signed [mvng_pkg::NRM_W-1:0]    normal_y;
    logic signed [mvng_pkg::NRM_W-1:0]    normal_z;
    logic                                 zero_sum;

    modport source (output valid, normal_x, normal_y, normal_z, zero_sum, input ready);
    modport sink   (input valid, normal_x, normal_y, normal_z, zero_sum, output ready);
endinterface

/* src/mesh_vertex_normal_generator_core.sv */
// ----------------------------------------------------------------------------
// mesh_vertex_normal_generator_core
// Smooth vertex normals by averaging unit face normals of a triangle mesh.
//
//   channel   dir  payload                                      transfer when
//   i_in      in   operation, vertex_index, pos_x/y/z, corners  valid & ready
//   o_out     out  normal_x/y/z (Q1.14), zero_sum               valid & ready
//
// The normaliser runs a one-bit-per-cycle common shift, 3 squares and
// 45 root-search steps; reads and triangles use it unless the sum or the
// cross product is zero. After reset a clearing pass over all
// VERTEX_COUNT entries zeroes the accumulators; i_in.ready stays low
// meanwhile. One item at a time; a read result waits in the output
// register without holding off the next item.
// ----------------------------------------------------------------------------
module mesh_vertex_normal_generator_core #(
    parameter int VERTEX_COUNT = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mvng_in_if.sink     i_in,
    mvng_out_if.source  o_out
);
    localparam int AW   = $clog2(VERTEX_COUNT);
    localparam int PW   = 3 * mvng_pkg::POS_W;
    localparam int ACW  = 3 * mvng_pkg::ACC_W;
    localparam int EW   = mvng_pkg::EDGE_W;
    localparam int CW   = mvng_pkg::CROSS_W;
    localparam int AccW = mvng_pkg::ACC_W;
    localparam int SW   = mvng_pkg::ACC_W + 1;
    localparam int NW   = mvng_pkg::NRM_W;
    localparam int PSW  = mvng_pkg::POS_W;

    mvng_pkg::t_state r_state, n_state;

    logic [AW-1:0]          r_clr;
    logic [AW-1:0]          r_crn [3];
    logic [AW-1:0]          r_vi;
    logic                   r_vi_ok;
    logic [PW-1:0]          r_pa, r_pb;
    logic signed [EW-1:0]   r_e1 [3];
    logic signed [EW-1:0]   r_e2 [3];
    logic signed [CW-1:0]   r_cr [3];
    logic signed [CW-1:0]   r_prod;
    logic [2:0]             r_k;
    logic [1:0]             r_j;
    logic signed [NW-1:0]   r_n [3];
    logic                   r_zs;
    logic                   r_ov;
    logic signed [NW-1:0]   r_ox, r_oy, r_oz;
    logic                   r_ozs;

    logic                   in_xfer;
    logic                   is_load, is_tri, is_read;
    logic                   load_ok, tri_ok, read_ok;
    logic                   out_load;

    logic                   pos_we;
    logic [AW-1:0]          pos_raddr;
    logic [PW-1:0]          pos_rdata;
    logic                   acc_we;
    logic [AW-1:0]          acc_waddr, acc_raddr;
    logic [ACW-1:0]         acc_wdata, acc_rdata;

    logic signed [AccW-1:0] acc_old [3];
    logic signed [AccW-1:0] acc_new [3];
    logic signed [SW-1:0]   acc_sum [3];
    logic                   acc_zero;
    logic                   cr_zero;

    logic signed [EW-1:0]   mul_a, mul_b;
    logic signed [2*EW-1:0] mul_p;
    logic [2:0]             k_prev;

    logic                   norm_start;
    logic signed [CW-1:0]   norm_vx, norm_vy, norm_vz;
    mvng_pkg::t_norm_res    norm_res;

    function automatic logic idx_ok(input logic [mvng_pkg::IDX_W-1:0] idx);
        idx_ok = (32'(idx) < VERTEX_COUNT);
    endfunction

    function automatic logic signed [EW-1:0] crd(input logic [PW-1:0] p,
                                                  input int           n);
        logic signed [PSW-1:0] v;
        v   = p[PW-1-n*PSW -: PSW];
        crd = EW'(v);
    endfunction

    // ---- input decode ----
    assign in_xfer = i_in.valid && i_in.ready;
    assign is_load = in_xfer && (i_in.operation == mvng_pkg::OP_LOAD);
    assign is_tri  = in_xfer && (i_in.operation == mvng_pkg::OP_TRI);
    assign is_read = in_xfer && (i_in.operation == mvng_pkg::OP_READ);
    assign load_ok = idx_ok(i_in.vertex_index);
    assign tri_ok  = idx_ok(i_in.corner_a) && idx_ok(i_in.corner_b)
                  && idx_ok(i_in.corner_c);
    assign read_ok = load_ok;

    assign i_in.ready = (r_state == mvng_pkg::ST_IDLE);

    // ---- stores ----
    assign pos_we = is_load && load_ok;

    always_comb begin
        case (r_state)
            mvng_pkg::ST_RD_B: pos_raddr = r_crn[1];
            mvng_pkg::ST_RD_C: pos_raddr = r_crn[2];
            default:           pos_raddr = r_crn[0];
        endcase
    end

    mvng_ram #(.WIDTH(PW), .DEPTH(VERTEX_COUNT)) u_pos_ram (
        .i_clk   (i_clk),
        .i_we    (pos_we),
        .i_waddr (AW'(i_in.vertex_index)),
        .i_wdata ({i_in.pos_x, i_in.pos_y, i_in.pos_z}),
        .i_raddr (pos_raddr),
        .o_rdata (pos_rdata)
    );

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            acc_old[i] = acc_rdata[ACW-1-i*AccW -: AccW];
            acc_sum[i] = SW'(acc_old[i]) + SW'(r_n[i]);
            if (acc_sum[i] > SW'(mvng_pkg::ACC_MAX)) begin
                acc_new[i] = mvng_pkg::ACC_MAX;
            end else if (acc_sum[i] < SW'(mvng_pkg::ACC_MIN)) begin
                acc_new[i] = mvng_pkg::ACC_MIN;
            end else begin
                acc_new[i] = AccW'(acc_sum[i]);
            end
        end
    end

    assign acc_zero = (acc_rdata == '0);

    always_comb begin
        acc_we    = 1'b0;
        acc_waddr = r_clr;
        acc_wdata = '0;
        if (r_state == mvng_pkg::ST_CLEAR) begin
            acc_we = 1'b1;
        end else if (pos_we) begin
            acc_we    = 1'b1;
            acc_waddr = AW'(i_in.vertex_index);
        end else if (r_state == mvng_pkg::ST_ACC_WR) begin
            acc_we    = 1'b1;
            acc_waddr = r_crn[r_j];
            acc_wdata = {acc_new[0], acc_new[1], acc_new[2]};
        end
        acc_raddr = (r_state == mvng_pkg::ST_RD_ACC) ? r_vi : r_crn[r_j];
    end

    mvng_ram #(.WIDTH(ACW), .DEPTH(VERTEX_COUNT)) u_acc_ram (
        .i_clk   (i_clk),
        .i_we    (acc_we),
        .i_waddr (acc_waddr),
        .i_wdata (acc_wdata),
        .i_raddr (acc_raddr),
        .o_rdata (acc_rdata)
    );

    // ---- cross product: one multiplier, six products ----
    always_comb begin
        unique case (r_k)
            3'd0:    begin mul_a = r_e1[1]; mul_b = r_e2[2]; end
            3'd1:    begin mul_a = r_e1[2]; mul_b = r_e2[1]; end
            3'd2:    begin mul_a = r_e1[2]; mul_b = r_e2[0]; end
            3'd3:    begin mul_a = r_e1[0]; mul_b = r_e2[2]; end
            3'd4:    begin mul_a = r_e1[0]; mul_b = r_e2[1]; end
            default: begin mul_a = r_e1[1]; mul_b = r_e2[0]; end
        endcase
    end

    assign mul_p   = mul_a * mul_b;
    assign k_prev  = r_k - 3'd1;
    assign cr_zero = (r_cr[0] == '0) && (r_cr[1] == '0) && (r_cr[2] == '0);

    // ---- normaliser ----
    assign norm_start = ((r_state == mvng_pkg::ST_CHECK) && !cr_zero)
                     || ((r_state == mvng_pkg::ST_RD_CHK) && r_vi_ok && !acc_zero);
    assign norm_vx = (r_state == mvng_pkg::ST_RD_CHK) ? CW'(acc_old[0]) : r_cr[0];
    assign norm_vy = (r_state == mvng_pkg::ST_RD_CHK) ? CW'(acc_old[1]) : r_cr[1];
    assign norm_vz = (r_state == mvng_pkg::ST_RD_CHK) ? CW'(acc_old[2]) : r_cr[2];

    mvng_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (norm_start),
        .i_vx    (norm_vx),
        .i_vy    (norm_vy),
        .i_vz    (norm_vz),
        .o_res   (norm_res)
    );

    // ---- sequencer ----
    assign out_load = (r_state == mvng_pkg::ST_OUT) && (!r_ov || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mvng_pkg::ST_CLEAR;
            r_clr   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == mvng_pkg::ST_CLEAR) begin
                r_clr <= r_clr + AW'(1);
            end
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mvng_pkg::ST_CLEAR: begin
                if (r_clr == AW'(VERTEX_COUNT - 1)) n_state = mvng_pkg::ST_IDLE;
            end
            mvng_pkg::ST_IDLE: begin
                if (is_tri && tri_ok) n_state = mvng_pkg::ST_RD_A;
                else if (is_read)     n_state = mvng_pkg::ST_RD_ACC;
            end
            mvng_pkg::ST_RD_A:     n_state = mvng_pkg::ST_RD_B;
            mvng_pkg::ST_RD_B:     n_state = mvng_pkg::ST_RD_C;
            mvng_pkg::ST_RD_C:     n_state = mvng_pkg::ST_EDGE;
            mvng_pkg::ST_EDGE:     n_state = mvng_pkg::ST_CROSS;
            mvng_pkg::ST_CROSS: begin
                if (r_k == 3'd6) n_state = mvng_pkg::ST_CHECK;
            end
            mvng_pkg::ST_CHECK: begin
                n_state = cr_zero ? mvng_pkg::ST_IDLE : mvng_pkg::ST_TRI_NORM;
            end
            mvng_pkg::ST_TRI_NORM: begin
                if (norm_res.done) n_state = mvng_pkg::ST_ACC_RD;
            end
            mvng_pkg::ST_ACC_RD:   n_state = mvng_pkg::ST_ACC_WR;
            mvng_pkg::ST_ACC_WR: begin
                n_state = (r_j == 2'd2) ? mvng_pkg::ST_IDLE : mvng_pkg::ST_ACC_RD;
            end
            mvng_pkg::ST_RD_ACC:   n_state = mvng_pkg::ST_RD_CHK;
            mvng_pkg::ST_RD_CHK: begin
                n_state = norm_start ? mvng_pkg::ST_RD_NORM : mvng_pkg::ST_OUT;
            end
            mvng_pkg::ST_RD_NORM: begin
                if (norm_res.done) n_state = mvng_pkg::ST_OUT;
            end
            mvng_pkg::ST_OUT: begin
                if (out_load) n_state = mvng_pkg::ST_IDLE;
            end
            default: n_state = mvng_pkg::ST_IDLE;
        endcase
    end

    // ---- datapath registers ----
    always_ff @(posedge i_clk) begin
        case (r_state)
            mvng_pkg::ST_IDLE: begin
                r_crn[0] <= AW'(i_in.corner_a);
                r_crn[1] <= AW'(i_in.corner_b);
                r_crn[2] <= AW'(i_in.corner_c);
                r_vi     <= AW'(i_in.vertex_index);
                r_vi_ok  <= read_ok;
                r_j      <= 2'd0;
                r_k      <= 3'd0;
            end
            mvng_pkg::ST_RD_B: r_pa <= pos_rdata;
            mvng_pkg::ST_RD_C: r_pb <= pos_rdata;
            mvng_pkg::ST_EDGE: begin
                for (int i = 0; i < 3; i++) begin
                    r_e1[i] <= crd(r_pb, i) - crd(r_pa, i);
                    r_e2[i] <= crd(pos_rdata, i) - crd(r_pa, i);
                end
            end
            mvng_pkg::ST_CROSS: begin
                r_prod <= CW'(mul_p);
                r_k    <= r_k + 3'd1;
                // fold the product taken last cycle
                if (r_k != 3'd0) begin
                    if (!k_prev[0]) begin
                        r_cr[k_prev[2:1]] <= r_prod;
                    end else begin
                        r_cr[k_prev[2:1]] <= r_cr[k_prev[2:1]] - r_prod;
                    end
                end
            end
            mvng_pkg::ST_TRI_NORM, mvng_pkg::ST_RD_NORM: begin
                if (norm_res.done) begin
                    r_n[0] <= norm_res.qx;
                    r_n[1] <= norm_res.qy;
                    r_n[2] <= norm_res.qz;
                    r_zs   <= 1'b0;
                end
            end
            mvng_pkg::ST_ACC_WR: r_j <= r_j + 2'd1;
            mvng_pkg::ST_RD_CHK: begin
                if (!norm_start) begin
                    r_n[0] <= '0;
                    r_n[1] <= '0;
                    r_n[2] <= '0;
                    r_zs   <= 1'b1;
                end
            end
            default: ;
        endcase
        if (out_load) begin
            r_ox  <= r_n[0];
            r_oy  <= r_n[1];
            r_oz  <= r_n[2];
            r_ozs <= r_zs;
        end
    end

    assign o_out.valid    = r_ov;
    assign o_out.normal_x = r_ox;
    assign o_out.normal_y = r_oy;
    assign o_out.normal_z = r_oz;
    assign o_out.zero_sum = r_ozs;
endmodule

/* src/mvng_ram.sv */
// ----------------------------------------------------------------------------
// mvng_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mvng_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* src/mvng_norm.sv */
// ----------------------------------------------------------------------------
// mvng_norm
// Iterative unit-vector scaler: common shift, squares, bit-serial root search.
// ----------------------------------------------------------------------------
module mvng_norm (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [mvng_pkg::CROSS_W-1:0] i_vx,
    input  logic signed [mvng_pkg::CROSS_W-1:0] i_vy,
    input  logic signed [mvng_pkg::CROSS_W-1:0] i_vz,
    output mvng_pkg::t_norm_res                 o_res
);
    localparam int CW = mvng_pkg::CROSS_W;
    localparam int MW = mvng_pkg::MAG_W;

    mvng_pkg::t_nstate r_state, n_state;

    logic [CW-1:0]           r_m [3];
    logic [2:0]              r_neg;
    logic [31:0]             r_sq [3];
    logic [33:0]             r_len;
    logic [1:0]              r_idx;
    logic [3:0]              r_bit;
    logic [14:0]             r_r;
    logic [65:0]             r_p;    // r*r*len
    logic [48:0]             r_rl;   // r*len
    logic signed [15:0]      r_q [3];

    logic                    big;
    logic [65:0]             tt;
    logic [65:0]             target;
    logic                    take;
    logic [14:0]             r_new;
    logic signed [15:0]      qv;

    function automatic logic [CW-1:0] mag(input logic signed [CW-1:0] v);
        mag = v[CW-1] ? CW'(-v) : CW'(v);
    endfunction

    assign big = (r_m[0][CW-1:MW] != '0) || (r_m[1][CW-1:MW] != '0)
              || (r_m[2][CW-1:MW] != '0);

    // (r + 2^b)^2 * L = P + R*2^(b+1) + L*2^(2b)
    assign target = {6'b0, r_sq[r_idx], 28'b0};
    assign tt     = r_p + ({17'b0, r_rl} << (r_bit + 4'd1))
                  + ({32'b0, r_len} << {r_bit, 1'b0});
    assign take   = (r_r != mvng_pkg::UNIT_Q) && (tt <= target);
    assign r_new  = take ? (r_r | (15'd1 << r_bit)) : r_r;
    assign qv     = 16'(r_new);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mvng_pkg::NS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mvng_pkg::NS_IDLE:  if (i_start) n_state = mvng_pkg::NS_SHIFT;
            mvng_pkg::NS_SHIFT: if (!big) n_state = mvng_pkg::NS_SQ;
            mvng_pkg::NS_SQ:    if (r_idx == 2'd2) n_state = mvng_pkg::NS_LEN;
            mvng_pkg::NS_LEN:   n_state = mvng_pkg::NS_SRCH;
            mvng_pkg::NS_SRCH:  if (r_bit == 4'd0 && r_idx == 2'd2) begin
                n_state = mvng_pkg::NS_DONE;
            end
            mvng_pkg::NS_DONE:  n_state = mvng_pkg::NS_IDLE;
            default:            n_state = mvng_pkg::NS_IDLE;
        endcase
        o_res.done = (r_state == mvng_pkg::NS_DONE);
        o_res.qx   = r_q[0];
        o_res.qy   = r_q[1];
        o_res.qz   = r_q[2];
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            mvng_pkg::NS_IDLE: begin
                if (i_start) begin
                    r_m[0] <= mag(i_vx);
                    r_m[1] <= mag(i_vy);
                    r_m[2] <= mag(i_vz);
                    r_neg  <= {i_vz[CW-1], i_vy[CW-1], i_vx[CW-1]};
                    r_idx  <= 2'd0;
                end
            end
            mvng_pkg::NS_SHIFT: begin
                if (big) begin
                    r_m[0] <= r_m[0] >> 1;
                    r_m[1] <= r_m[1] >> 1;
                    r_m[2] <= r_m[2] >> 1;
                end
            end
            mvng_pkg::NS_SQ: begin
                r_sq[r_idx] <= 32'(r_m[r_idx][MW-1:0]) * 32'(r_m[r_idx][MW-1:0]);
                r_idx       <= (r_idx == 2'd2) ? 2'd0 : r_idx + 2'd1;
            end
            mvng_pkg::NS_LEN: begin
                r_len <= 34'(r_sq[0]) + 34'(r_sq[1]) + 34'(r_sq[2]);
                r_bit <= 4'd14;
                r_r   <= '0;
                r_p   <= '0;
                r_rl  <= '0;
                r_idx <= 2'd0;
            end
            mvng_pkg::NS_SRCH: begin
                if (r_bit == 4'd0) begin
                    r_q[r_idx] <= r_neg[r_idx] ? -qv : qv;
                    r_idx      <= r_idx + 2'd1;
                    r_bit      <= 4'd14;
                    r_r        <= '0;
                    r_p        <= '0;
                    r_rl       <= '0;
                end else begin
                    if (take) begin
                        r_p  <= tt;
                        r_rl <= r_rl + ({15'b0, r_len} << r_bit);
                        r_r  <= r_new;
                    end
                    r_bit <= r_bit - 4'd1;
                end
            end
            default: ;
        endcase
    end
endmodule

/* test/tb_mesh_vertex_normal_generator_core.sv */
// ----------------------------------------------------------------------------
// tb_mesh_vertex_normal_generator_core
// Drives load, triangle, read and unused operations into the normal generator and
// checks each normal read back against fixed values or an in-bench accumulator model.
// ----------------------------------------------------------------------------
module tb_mesh_vertex_normal_generator_core;

    localparam int NV = 1024;
    localparam int IW = mvng_pkg::IDX_W;
    localparam int OP_SPARE = 3;

    typedef struct {
        logic [1:0]         operation;
        logic [IW-1:0]      vertex_index;
        logic signed [15:0] pos_x, pos_y, pos_z;
        logic [IW-1:0]      corner_a, corner_b, corner_c;
        bit                 fixed;
        logic signed [15:0] nx, ny, nz;
        logic               zs;
    } t_row;

    typedef struct {
        logic signed [15:0] nx, ny, nz;
        logic               zs;
    } t_normal;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    mvng_in_if  in_ch();
    mvng_out_if out_ch();

    mesh_vertex_normal_generator_core #(.VERTEX_COUNT(NV)) u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    longint  vert_pos [NV][3];
    bit      vert_loaded [NV];
    longint  acc_sum [NV][3];
    t_normal normals_due[$];
    int      n_errors = 0;
    bit      idle_free = 1'b0;
    bit      stim_done = 1'b0;

    task automatic report(input string what);
        $display("mismatch: %s", what);
        n_errors++;
    endtask

    function automatic void to_unit(input longint v[3], output longint q[3]);
        longint m[3], top, len2, tgt, r, t;
        int s;
        len2 = 0;
        s = 0;
        for (int i = 0; i < 3; i++) m[i] = v[i] < 0 ? -v[i] : v[i];
        top = m[0];
        if (m[1] > top) top = m[1];
        if (m[2] > top) top = m[2];
        while ((top >>> s) >= 65536) s++;
        for (int i = 0; i < 3; i++) begin
            m[i] = m[i] >>> s;
            len2 += m[i] * m[i];
        end
        for (int i = 0; i < 3; i++) begin
            tgt = (m[i] * m[i]) << 28;
            r = 0;
            if (len2 != 0) begin
                for (int b = 14; b >= 0; b--) begin
                    t = r | (longint'(1) << b);
                    if (t <= 16384 && t * t * len2 <= tgt) r = t;
                end
            end
            q[i] = v[i] < 0 ? -r : r;
        end
    endfunction

    function automatic longint clamp_acc(input longint s);
        if (s > 8388607) return 8388607;
        if (s < -8388608) return -8388608;
        return s;
    endfunction

    // Advance the accumulator model by one accepted item; returns 1 for a read, with its result in res.
    function automatic bit predict_normal(input t_row r, output t_normal res);
        longint e1[3], e2[3], cr[3], q[3], s[3];
        int a, b, c, v;
        a = int'(r.corner_a); b = int'(r.corner_b); c = int'(r.corner_c);
        v = int'(r.vertex_index);
        res = '{'0, '0, '0, 1'b1};
        case (r.operation)
            mvng_pkg::OP_LOAD: begin
                for (int i = 0; i < 3; i++) acc_sum[v][i] = 0;
                vert_pos[v][0] = longint'(r.pos_x); vert_pos[v][1] = longint'(r.pos_y);
                vert_pos[v][2] = longint'(r.pos_z);
                vert_loaded[v] = 1'b1;
                return 1'b0;
            end
            mvng_pkg::OP_TRI: begin
                for (int i = 0; i < 3; i++) begin
                    e1[i] = vert_pos[b][i] - vert_pos[a][i];
                    e2[i] = vert_pos[c][i] - vert_pos[a][i];
                end
                cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
                cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
                cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
                if (cr[0] == 0 && cr[1] == 0 && cr[2] == 0) return 1'b0;
                to_unit(cr, q);
                for (int i = 0; i < 3; i++) begin
                    acc_sum[a][i] = clamp_acc(acc_sum[a][i] + q[i]);
                    acc_sum[b][i] = clamp_acc(acc_sum[b][i] + q[i]);
                    acc_sum[c][i] = clamp_acc(acc_sum[c][i] + q[i]);
                end
                return 1'b0;
            end
            mvng_pkg::OP_READ: begin
                for (int i = 0; i < 3; i++) s[i] = acc_sum[v][i];
                if (s[0] != 0 || s[1] != 0 || s[2] != 0) begin
                    to_unit(s, q);
                    res = '{q[0][15:0], q[1][15:0], q[2][15:0], 1'b0};
                end
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic bit take_gap();
        return !idle_free && ($urandom_range(99) < 9);
    endfunction

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send_item(input t_row r);
        t_normal res;
        while (take_gap()) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.operation    <= r.operation;
        in_ch.vertex_index <= r.vertex_index;
        in_ch.pos_x <= r.pos_x; in_ch.pos_y <= r.pos_y; in_ch.pos_z <= r.pos_z;
        in_ch.corner_a <= r.corner_a; in_ch.corner_b <= r.corner_b;
        in_ch.corner_c <= r.corner_c;
        do @(posedge i_clk); while (!in_ch.ready);
        if (predict_normal(r, res)) begin
            if (r.fixed) res = '{r.nx, r.ny, r.nz, r.zs};
            normals_due.push_back(res);
        end
        @(negedge i_clk);
    endtask

    function automatic t_row mk(input int op, input int v, input int px, input int py,
                                input int pz, input int a, input int b, input int c);
        t_row r;
        r = '{2'(op), IW'(v), 16'(px), 16'(py), 16'(pz), IW'(a), IW'(b), IW'(c),
              1'b0, '0, '0, '0, 1'b0};
        return r;
    endfunction

    function automatic t_row mk_rd(input int v, input int nx, input int ny, input int nz,
                                   input bit zs);
        t_row r;
        r = mk(mvng_pkg::OP_READ, v, 0, 0, 0, 0, 0, 0);
        r.fixed = 1'b1; r.nx = 16'(nx); r.ny = 16'(ny); r.nz = 16'(nz); r.zs = zs;
        return r;
    endfunction

    // random position, full width some of the time
    function automatic int rnd_pos();
        if ($urandom_range(3) == 0) return int'($signed(16'($urandom)));
        return int'($signed(16'($urandom_range(0, 1023)))) - 512;
    endfunction

    // output side: random stalls, compare against oldest expected normal
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_ch.ready <= !take_gap();
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (normals_due.size() == 0) begin
                report("normal returned with none expected");
            end else begin
                t_normal e;
                e = normals_due.pop_front();
                if (out_ch.normal_x !== e.nx)
                    report($sformatf("normal_x %0d want %0d", out_ch.normal_x, e.nx));
                if (out_ch.normal_y !== e.ny)
                    report($sformatf("normal_y %0d want %0d", out_ch.normal_y, e.ny));
                if (out_ch.normal_z !== e.nz)
                    report($sformatf("normal_z %0d want %0d", out_ch.normal_z, e.nz));
                if (out_ch.zero_sum !== e.zs)
                    report($sformatf("zero_sum %0b want %0b", out_ch.zero_sum, e.zs));
            end
        end
    end

    initial begin
        t_row dir_rows[$];
        int cnt, op, a, b, c, v, k;
        in_ch.valid = 1'b0; in_ch.operation = '0; in_ch.vertex_index = '0;
        in_ch.pos_x = '0; in_ch.pos_y = '0; in_ch.pos_z = '0;
        in_ch.corner_a = '0; in_ch.corner_b = '0; in_ch.corner_c = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        dir_rows = '{
            mk_rd(0, 0, 0, 0, 1'b1),                 // after reset: zero sum
            mk_rd(1023, 0, 0, 0, 1'b1),
            mk(mvng_pkg::OP_LOAD, 0, 0, 0, 0, 0, 0, 0),
            mk(mvng_pkg::OP_LOAD, 1, 256, 0, 0, 0, 0, 0),
            mk(mvng_pkg::OP_LOAD, 2, 0, 256, 0, 0, 0, 0),
            mk(mvng_pkg::OP_TRI, 0, 0, 0, 0, 0, 1, 2),         // +z face
            mk_rd(0, 0, 0, 16384, 1'b0),
            mk_rd(2, 0, 0, 16384, 1'b0),
            mk(mvng_pkg::OP_TRI, 0, 0, 0, 0, 0, 2, 1),         // opposite winding cancels
            mk_rd(1, 0, 0, 0, 1'b1),
            mk(mvng_pkg::OP_TRI, 0, 0, 0, 0, 0, 0, 1),         // degenerate
            mk_rd(0, 0, 0, 0, 1'b1),
            mk(mvng_pkg::OP_LOAD, 1021, 32767, -32768, 32767, 0, 0, 0),
            mk(mvng_pkg::OP_LOAD, 1022, -32768, 32767, -32768, 0, 0, 0),
            mk(mvng_pkg::OP_LOAD, 1023, -32768, -32768, 32767, 0, 0, 0),
            mk(mvng_pkg::OP_TRI, 0, 0, 0, 0, 1021, 1022, 1023),
            mk(mvng_pkg::OP_TRI, 0, 0, 0, 0, 1023, 1021, 1022),
            mk(mvng_pkg::OP_READ, 1021, 0, 0, 0, 0, 0, 0),
            mk(mvng_pkg::OP_READ, 1022, 0, 0, 0, 0, 0, 0),
            mk(mvng_pkg::OP_TRI, 0, 0, 0, 0, 0, 1, 1023),
            mk(mvng_pkg::OP_READ, 1023, 0, 0, 0, 0, 0, 0),
            mk(OP_SPARE, 5, -1, -1, -1, 1023, 1023, 1023),     // unused code
            mk(mvng_pkg::OP_LOAD, 1021, 0, 0, 0, 0, 0, 0),     // reload clears sum
            mk_rd(1021, 0, 0, 0, 1'b1)
        };
        foreach (dir_rows[i]) send_item(dir_rows[i]);

        // saturation: same face many times on three vertices
        send_item(mk(mvng_pkg::OP_LOAD, 3, 0, 0, 0, 0, 0, 0));
        send_item(mk(mvng_pkg::OP_LOAD, 4, 0, 0, 256, 0, 0, 0));
        send_item(mk(mvng_pkg::OP_LOAD, 5, 256, 0, 0, 0, 0, 0));
        idle_free = 1'b1;
        repeat (513) send_item(mk(mvng_pkg::OP_TRI, 0, 0, 0, 0, 3, 4, 5));
        idle_free = 1'b0;
        send_item(mk(mvng_pkg::OP_READ, 3, 0, 0, 0, 0, 0, 0));
        send_item(mk_rd(6, 0, 0, 0, 1'b1));

        // random: mostly small meshes over loaded vertices
        for (cnt = 0; cnt < 60; cnt++) begin
            if (cnt == 20) idle_free = 1'b1;
            if (cnt == 30) idle_free = 1'b0;
            k = $urandom_range(99);
            v = $urandom_range(0, 1023);
            if (k < 25) begin
                if ($urandom_range(1)) v = $urandom_range(0, 15);
                send_item(mk(mvng_pkg::OP_LOAD, v, rnd_pos(), rnd_pos(), rnd_pos(),
                             0, 0, 0));
            end else if (k < 65) begin
                a = $urandom_range(0, 1023); b = $urandom_range(0, 1023);
                c = $urandom_range(0, 1023);
                if ($urandom_range(3) != 0) begin
                    a = $urandom_range(0, 15); b = $urandom_range(0, 15);
                    c = $urandom_range(0, 15);
                end
                // never touch an unloaded corner
                if (vert_loaded[a] && vert_loaded[b] && vert_loaded[c])
                    send_item(mk(mvng_pkg::OP_TRI, 0, 0, 0, 0, a, b, c));
                else
                    cnt--;
            end else if (k < 95) begin
                if ($urandom_range(3) != 0) v = $urandom_range(0, 15);
                send_item(mk(mvng_pkg::OP_READ, v, 0, 0, 0, 0, 0, 0));
            end else begin
                send_item(mk(OP_SPARE, v, rnd_pos(), rnd_pos(), rnd_pos(),
                             $urandom_range(0, 1023), $urandom_range(0, 1023),
                             $urandom_range(0, 1023)));
            end
        end
        in_ch.valid <= 1'b0;
        stim_done = 1'b1;
    end

    initial begin
        wait (stim_done);
        while (normals_due.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (n_errors == 0 && normals_due.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin
        #1000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

/* mesh_vertex_normal_generator_core.f */
src/mvng_pkg.sv
src/mvng_if.sv
src/mvng_ram.sv
src/mvng_norm.sv
src/mesh_vertex_normal_generator_core.sv
test/tb_mesh_vertex_normal_generator_core.sv
